// ===== src/sac_pkg.sv =====
// Shared types and constants for the set-associative read cache.
// Used by sac_lookup, set_assoc_read_cache and sac_checker; depends on nothing.

package sac_pkg;

   // Default geometry: each value must be a power of two
   localparam int unsigned SETS_DEFAULT       = 64;
   localparam int unsigned WAYS_DEFAULT       = 4;
   localparam int unsigned LINE_WORDS_DEFAULT = 8;

   // Only address bits 19..0 take part in a lookup
   localparam int unsigned LOOKUP_ADDR_BITS = 20;
   localparam int unsigned BYTE_BITS        = 2;

   localparam int unsigned AGE_W         = 2;
   localparam logic [1:0]  AGE_MAX       = 2'd3;
   localparam int unsigned PENALTY_W     = 8;
   localparam logic [7:0]  PENALTY_RESET = 8'd49;
   localparam int unsigned DATA_W        = 32;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_DATA
   } state_type;

   typedef enum logic {
      CMD_READ = 1'b0,
      CMD_FILL = 1'b1
   } command_type;

endpackage

// ===== src/set_assoc_read_cache.sv =====
// Top level of the set-associative read cache: control, tag RAM, data RAM.
// Depends on sac_pkg, sac_ram and sac_lookup.
//
//   channel   ports                                        handshake
//   request   req_command, req_address, req_fill_data      start, busy
//   response  rsp_read_data, rsp_hit, rsp_stall_cycles     rsp_strobe
//   config    csr_write_data (miss_penalty)                csr_write_enable
//
// A fill request writes the data RAM, a read miss passes tag RAM read, then tag write-back,
// a read hit passes tag RAM read, then data RAM read, then response register.
// The response is registered and shown for exactly one cycle; busy is low then,
// so the next request is taken while it is shown. The receiver cannot stall.
// After reset a clearing pass writes every tag row with busy high.

module set_assoc_read_cache #(
   parameter int unsigned SETS       = sac_pkg::SETS_DEFAULT,
   parameter int unsigned WAYS       = sac_pkg::WAYS_DEFAULT,
   parameter int unsigned LINE_WORDS = sac_pkg::LINE_WORDS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_command,
   input  logic [31:0]                     req_address,
   input  logic [sac_pkg::DATA_W-1:0]      req_fill_data,
   output logic                            rsp_strobe,
   output logic [sac_pkg::DATA_W-1:0]      rsp_read_data,
   output logic                            rsp_hit,
   output logic [sac_pkg::PENALTY_W-1:0]   rsp_stall_cycles,
   input  logic                            csr_write_enable,
   input  logic [sac_pkg::PENALTY_W-1:0]   csr_write_data
);

   localparam int unsigned SET_W      = $clog2(SETS);
   localparam int unsigned WAY_W      = $clog2(WAYS);
   localparam int unsigned WORD_W     = $clog2(LINE_WORDS);
   localparam int unsigned OFF_W      = sac_pkg::BYTE_BITS + WORD_W;
   localparam int unsigned TAG_W      = sac_pkg::LOOKUP_ADDR_BITS - OFF_W - SET_W;
   localparam int unsigned ROW_W      = WAYS * (1 + sac_pkg::AGE_W + TAG_W);
   localparam int unsigned DATA_DEPTH = SETS * WAYS * LINE_WORDS;
   localparam int unsigned DATA_AW    = SET_W + WAY_W + WORD_W;

   sac_pkg::state_type state_ff, state_in;

   logic [SET_W-1:0]                clr_ff, clr_in;
   logic [WAY_W-1:0]                fill_way_ff, fill_way_in;
   logic [sac_pkg::PENALTY_W-1:0]   penalty_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [sac_pkg::DATA_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                            rsp_hit_ff, rsp_hit_in;
   logic [sac_pkg::PENALTY_W-1:0]   rsp_stall_ff, rsp_stall_in;
   logic [SET_W-1:0]                set_ff;
   logic [TAG_W-1:0]                tag_ff;
   logic [WORD_W-1:0]               word_ff;

   logic                            accept;
   logic [SET_W-1:0]                req_set;
   logic [TAG_W-1:0]                req_tag;
   logic [WORD_W-1:0]               req_word;

   logic                            meta_we, meta_re;
   logic [SET_W-1:0]                meta_waddr;
   logic [ROW_W-1:0]                meta_wdata, meta_rdata, miss_row;
   logic                            data_we, data_re;
   logic [DATA_AW-1:0]              data_waddr, data_raddr;
   logic [sac_pkg::DATA_W-1:0]      data_rdata;

   logic [WAYS-1:0]                       rd_valid, new_valid;
   logic [WAYS-1:0][sac_pkg::AGE_W-1:0]   rd_ages, new_ages;
   logic [WAYS-1:0][TAG_W-1:0]            rd_tags, new_tags;
   logic                                  lk_hit;
   logic [WAY_W-1:0]                      lk_hit_way, lk_victim;

   // address fields of the incoming request
   assign req_word = req_address[sac_pkg::BYTE_BITS +: WORD_W];
   assign req_set  = req_address[OFF_W +: SET_W];
   assign req_tag  = req_address[OFF_W + SET_W +: TAG_W];

   assign busy   = (state_ff != sac_pkg::ST_IDLE);
   assign accept = start && !busy;

   // tag row layout: {valid, ages, tags}
   assign rd_valid = meta_rdata[ROW_W-1 -: WAYS];
   assign rd_ages  = meta_rdata[WAYS*TAG_W +: WAYS*sac_pkg::AGE_W];
   assign rd_tags  = meta_rdata[0 +: WAYS*TAG_W];

   sac_lookup #(
      .WAYS  (WAYS),
      .TAG_W (TAG_W)
   ) u_lookup (
      .valid      (rd_valid),
      .ages       (rd_ages),
      .tags       (rd_tags),
      .tag        (tag_ff),
      .hit        (lk_hit),
      .hit_way    (lk_hit_way),
      .victim_way (lk_victim),
      .new_ages   (new_ages)
   );

   // victim way becomes valid with the new tag
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         if (WAY_W'(w) == lk_victim) begin
            new_valid[w] = 1'b1;
            new_tags[w]  = tag_ff;
         end else begin
            new_valid[w] = rd_valid[w];
            new_tags[w]  = rd_tags[w];
         end
      end
   end

   assign miss_row   = {new_valid, new_ages, new_tags};
   assign data_waddr = {req_set, fill_way_ff, req_word};
   assign data_raddr = {set_ff, lk_hit_way, word_ff};

   sac_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_en   (meta_re),
      .rd_addr (req_set),
      .rd_data (meta_rdata)
   );

   sac_ram #(
      .WIDTH (sac_pkg::DATA_W),
      .DEPTH (DATA_DEPTH)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (data_waddr),
      .wr_data (req_fill_data),
      .rd_en   (data_re),
      .rd_addr (data_raddr),
      .rd_data (data_rdata)
   );

   // sequencer: next state, RAM strobes and response values
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      fill_way_in  = fill_way_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_stall_in = rsp_stall_ff;
      meta_we      = 1'b0;
      meta_re      = 1'b0;
      meta_waddr   = set_ff;
      meta_wdata   = miss_row;
      data_we      = 1'b0;
      data_re      = 1'b0;
      unique case (state_ff)
         sac_pkg::ST_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = clr_ff;
            meta_wdata = '0;
            clr_in     = clr_ff + SET_W'(1);
            if (clr_ff == SET_W'(SETS - 1)) begin
               state_in = sac_pkg::ST_IDLE;
            end
         end
         sac_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_command == sac_pkg::CMD_FILL) begin
                  data_we      = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_hit_in   = 1'b0;
                  rsp_stall_in = '0;
               end else begin
                  meta_re  = 1'b1;
                  state_in = sac_pkg::ST_LOOKUP;
               end
            end
         end
         sac_pkg::ST_LOOKUP: begin
            if (lk_hit) begin
               data_re  = 1'b1;
               state_in = sac_pkg::ST_DATA;
            end else begin
               meta_we      = 1'b1;
               fill_way_in  = lk_victim;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '1;
               rsp_hit_in   = 1'b0;
               rsp_stall_in = penalty_ff;
               state_in     = sac_pkg::ST_IDLE;
            end
         end
         sac_pkg::ST_DATA: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = data_rdata;
            rsp_hit_in   = 1'b1;
            rsp_stall_in = '0;
            state_in     = sac_pkg::ST_IDLE;
         end
         default: begin
            state_in = sac_pkg::ST_CLEAR;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sac_pkg::ST_CLEAR;
         clr_ff       <= '0;
         fill_way_ff  <= '0;
         penalty_ff   <= sac_pkg::PENALTY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fill_way_ff  <= fill_way_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            penalty_ff <= csr_write_data;
         end
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_stall_ff <= rsp_stall_in;
      if (accept) begin
         set_ff  <= req_set;
         tag_ff  <= req_tag;
         word_ff <= req_word;
      end
   end

   assign rsp_strobe       = rsp_valid_ff;
   assign rsp_read_data    = rsp_data_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_stall_cycles = rsp_stall_ff;

endmodule

// ===== src/sac_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing; holds cache tag rows and cache data words.

module sac_ram #(
   parameter int unsigned WIDTH  = 8,
   parameter int unsigned DEPTH  = 16,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/sac_lookup.sv =====
// Tag compare and replacement choice for one set row of the cache.
// Depends on sac_pkg for age constants.

module sac_lookup #(
   parameter int unsigned WAYS  = sac_pkg::WAYS_DEFAULT,
   parameter int unsigned TAG_W = 9,
   localparam int unsigned WAY_W = $clog2(WAYS)
) (
   input  logic [WAYS-1:0]                       valid,
   input  logic [WAYS-1:0][sac_pkg::AGE_W-1:0]   ages,
   input  logic [WAYS-1:0][TAG_W-1:0]            tags,
   input  logic [TAG_W-1:0]                      tag,
   output logic                                  hit,
   output logic [WAY_W-1:0]                      hit_way,
   output logic [WAY_W-1:0]                      victim_way,
   output logic [WAYS-1:0][sac_pkg::AGE_W-1:0]   new_ages
);

   logic [WAYS-1:0][sac_pkg::AGE_W-1:0] aged_twice;
   logic                                inv_found;
   logic [WAY_W-1:0]                    inv_way;
   logic [sac_pkg::AGE_W-1:0]           best_age;
   logic [WAY_W-1:0]                    oldest_way;

   function automatic logic [sac_pkg::AGE_W-1:0] age_up(input logic [sac_pkg::AGE_W-1:0] a);
      return (a == sac_pkg::AGE_MAX) ? a : a + sac_pkg::AGE_W'(1);
   endfunction

   // parallel tag compare, lowest matching way wins
   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (valid[w] && (tags[w] == tag)) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
      end
   end

   // lowest invalid way
   always_comb begin
      inv_found = 1'b0;
      inv_way   = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (!valid[w]) begin
            inv_found = 1'b1;
            inv_way   = WAY_W'(w);
         end
      end
   end

   // full set: age everything twice, highest-numbered oldest way goes
   always_comb begin
      best_age   = '0;
      oldest_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         aged_twice[w] = age_up(age_up(ages[w]));
         if (aged_twice[w] >= best_age) begin
            best_age   = aged_twice[w];
            oldest_way = WAY_W'(w);
         end
      end
   end

   // ages written back on a miss; the victim restarts at zero
   always_comb begin
      victim_way = inv_found ? inv_way : oldest_way;
      for (int w = 0; w < WAYS; w++) begin
         if (WAY_W'(w) == victim_way) begin
            new_ages[w] = '0;
         end else if (inv_found) begin
            new_ages[w] = age_up(ages[w]);
         end else begin
            new_ages[w] = aged_twice[w];
         end
      end
   end

endmodule

// ===== src/sac_checker.sv =====
// Port-level checks for set_assoc_read_cache, bound to the top level.
// Depends on sac_pkg for field widths and command codes.

module sac_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            req_command,
   input logic                            rsp_strobe,
   input logic [sac_pkg::DATA_W-1:0]      rsp_read_data,
   input logic                            rsp_hit,
   input logic [sac_pkg::PENALTY_W-1:0]   rsp_stall_cycles
);

   // a fill request answers in the next cycle with an all-zero response
   a_fill_resp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_command == sac_pkg::CMD_FILL)) |=>
         (rsp_strobe && (rsp_read_data == '0) && !rsp_hit && (rsp_stall_cycles == '0)))
      else $error("fill request not answered next cycle with zeros");

   // a read request makes the cache busy for its lookup, with no response yet
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_command == sac_pkg::CMD_READ)) |=> (busy && !rsp_strobe))
      else $error("read request did not enter lookup");

   // a response is only shown while new requests can be taken
   a_resp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response shown while busy");

   // a hit never reports stall cycles
   a_hit_nostall: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_hit) |-> (rsp_stall_cycles == '0))
      else $error("hit with nonzero stall cycles");

   // a non-hit read response carries all ones
   a_miss_ones: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_hit && (rsp_read_data != '0)) |-> (rsp_read_data == '1))
      else $error("miss response data is not all ones");

endmodule

bind set_assoc_read_cache sac_checker u_sac_checker (.*);
